// File: src/cfpm_pkg.sv
`default_nettype none
package cfpm_pkg;

  localparam int CODE_CAPACITY = 65536;
  localparam int NEST_DEPTH    = 1024;

  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 4;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = $clog2(CODE_CAPACITY) + 1;
  localparam int FILL_W   = $clog2(NEST_DEPTH) + 1;
  localparam int STACK_AW = $clog2(NEST_DEPTH);
  localparam int OUT_W    = 48;

  localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;

  localparam logic [CMD_W-1:0] CMD_PLUS  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_MINUS = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LT    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_GT    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DOT   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_COMMA = 4'd5;
  localparam logic [CMD_W-1:0] CMD_LSQ   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RSQ   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LPAR  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_RPAR  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_SLASH = 4'd10;
  localparam logic [CMD_W-1:0] CMD_STAR  = 4'd11;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_TOO_DEEP   = 3'd1,
    ST_NO_OPENER  = 3'd2,
    ST_WRONG_KIND = 3'd3,
    ST_UNCLOSED   = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_t;

  typedef struct packed {
    logic             last;
    logic             too_long;
    logic [POS_W-1:0] pos;
    logic [CMD_W-1:0] cmd;
    logic             kept;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             kind;
  } stack_entry_t;

  typedef struct packed {
    logic             hit;
    logic [CMD_W-1:0] cmd;
  } lookup_t;

  function automatic lookup_t cmd_lookup(input logic [BYTE_W-1:0] b);
    lookup_t r;
    r.hit = 1'b1;
    case (b)
      8'h2b: r.cmd = CMD_PLUS;
      8'h2d: r.cmd = CMD_MINUS;
      8'h3c: r.cmd = CMD_LT;
      8'h3e: r.cmd = CMD_GT;
      8'h2e: r.cmd = CMD_DOT;
      8'h2c: r.cmd = CMD_COMMA;
      8'h5b: r.cmd = CMD_LSQ;
      8'h5d: r.cmd = CMD_RSQ;
      8'h28: r.cmd = CMD_LPAR;
      8'h29: r.cmd = CMD_RPAR;
      8'h2f: r.cmd = CMD_SLASH;
      8'h2a: r.cmd = CMD_STAR;
      default: begin
        r.hit = 1'b0;
        r.cmd = CMD_PLUS;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/cfpm_ram.sv
`default_nettype none
module cfpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/cfpm_front.sv
`default_nettype none
module cfpm_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [cfpm_pkg::BYTE_W-1:0] code_byte,
  input  wire logic                        last,
  output cfpm_pkg::item_t                  item
);
  import cfpm_pkg::*;

  logic               comment_on;
  logic               comment_on_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  lookup_t            lk;
  logic               too_long;

  always_comb begin
    lk       = cmd_lookup(code_byte);
    too_long = (count >= COUNT_W'(CODE_CAPACITY));

    item.kept     = !comment_on && (code_byte != CHAR_HASH) && lk.hit;
    item.cmd      = item.kept ? lk.cmd : CMD_PLUS;
    item.pos      = item.kept ? count[POS_W-1:0] : '0;
    item.too_long = too_long;
    item.last     = last;

    comment_on_next = comment_on;
    count_next      = count;
    if (last) begin
      comment_on_next = 1'b0;
      count_next      = '0;
    end else begin
      if (comment_on) begin
        if (code_byte == CHAR_NEWLINE) begin
          comment_on_next = 1'b0;
        end
      end else if (code_byte == CHAR_HASH) begin
        comment_on_next = 1'b1;
      end
      if (item.kept && !too_long) begin
        count_next = count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_on <= 1'b0;
      count      <= '0;
    end else if (accept) begin
      comment_on <= comment_on_next;
      count      <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: src/cfpm_queue.sv
`default_nettype none
module cfpm_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cfpm_pkg::item_t push_item,
  output logic           not_full,
  input  wire logic      pop,
  output logic           head_valid,
  output cfpm_pkg::item_t head
);
  import cfpm_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign not_full   = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// File: src/cfpm_back.sv
`default_nettype none
module cfpm_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       head_valid,
  input  wire cfpm_pkg::item_t            head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [cfpm_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tlast
);
  import cfpm_pkg::*;

  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   fill_next;
  status_t             err;
  status_t             err_next;
  stack_entry_t        top;
  stack_entry_t        top_next;
  stack_entry_t        under;
  stack_entry_t        push_entry;
  logic                do_push;
  logic                is_open;
  logic                is_close;
  logic                kind;
  logic                matched;
  logic [FILL_W-1:0]   rd_fill;
  logic [STACK_AW-1:0] raddr;

  assign pop = head_valid && (!m_tvalid || m_tready);

  always_comb begin
    is_open    = (head.cmd == CMD_LSQ) || (head.cmd == CMD_LPAR);
    is_close   = (head.cmd == CMD_RSQ) || (head.cmd == CMD_RPAR);
    kind       = (head.cmd == CMD_LPAR) || (head.cmd == CMD_RPAR);
    push_entry = '{pos: head.pos, kind: kind};
    do_push    = 1'b0;
    matched    = 1'b0;
    err_next   = err;
    fill_next  = fill;
    top_next   = top;

    if (head.kept && head.too_long && err == ST_OK) begin
      err_next = ST_TOO_LONG;
    end
    if (head.kept && err_next == ST_OK) begin
      if (is_open) begin
        if (fill >= FILL_W'(NEST_DEPTH)) begin
          err_next = ST_TOO_DEEP;
        end else begin
          do_push   = 1'b1;
          fill_next = fill + FILL_W'(1);
          top_next  = push_entry;
        end
      end else if (is_close) begin
        if (fill == '0) begin
          err_next = ST_NO_OPENER;
        end else if (top.kind != kind) begin
          err_next = ST_WRONG_KIND;
        end else begin
          matched   = 1'b1;
          fill_next = fill - FILL_W'(1);
          top_next  = under;
        end
      end
    end
    if (head.last && err_next == ST_OK && fill_next != '0) begin
      err_next = ST_UNCLOSED;
    end

    // keep the entry just below the top prefetched
    rd_fill = (pop ? fill_next : fill) - FILL_W'(2);
    raddr   = rd_fill[STACK_AW-1:0];
  end

  cfpm_ram #(
    .WIDTH ($bits(stack_entry_t)),
    .DEPTH (NEST_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (pop && do_push),
    .waddr (fill[STACK_AW-1:0]),
    .wdata (push_entry),
    .raddr (raddr),
    .rdata (under)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      err      <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        m_tvalid <= 1'b1;
        if (head.last) begin
          fill <= '0;
          err  <= ST_OK;
        end else begin
          fill <= fill_next;
          err  <= err_next;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      top     <= top_next;
      m_tlast <= head.last;
      m_tdata <= {6'd0, err_next, matched && kind,
                  matched ? top.pos : {POS_W{1'b0}}, matched,
                  head.pos, head.cmd, head.kept};
    end
  end

endmodule
`default_nettype wire

// File: src/command_filter_pair_matcher.sv
// channel  dir  tdata (lowest bit up)                          tuser  tlast
// s_       in   code_byte[7:0]                                 -      last
// m_       out  kept, command[4], position[16], matched,       -      end_res
//               open_position[16], pair_kind, status[3], 0[6]
// one byte per cycle while m_tready is high; a result is registered in the queue, then at the output
// a two-word queue sits between the filter and the stack unit
// the stack unit does one push or pop per cycle unless m_tready stalls it; the entry below the top is prefetched
// rst clears the filter, queue and stack pointer; stack memory needs no clearing
// m_tready low stalls the stack unit, then the queue, then s_tready
`default_nettype none
module command_filter_pair_matcher (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [cfpm_pkg::BYTE_W-1:0]  s_tdata,  // code_byte
  input  wire logic                         s_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [cfpm_pkg::OUT_W-1:0]        m_tdata,  // see table above
  output logic                              m_tlast
);
  import cfpm_pkg::*;

  item_t front_item;
  item_t head;
  logic  head_valid;
  logic  pop;
  logic  accept;

  assign accept = s_tvalid && s_tready;

  cfpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_byte (s_tdata),
    .last      (s_tlast),
    .item      (front_item)
  );

  cfpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_item  (front_item),
    .not_full   (s_tready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cfpm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

`ifndef SYNTH
  logic             a_kept;
  logic [CMD_W-1:0] a_cmd;
  logic             a_matched;
  logic [2:0]       a_status;
  assign a_kept    = m_tdata[0];
  assign a_cmd     = m_tdata[4:1];
  assign a_matched = m_tdata[21];
  assign a_status  = m_tdata[41:39];

  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && a_matched |-> a_status == ST_OK || (m_tlast && a_status == ST_UNCLOSED))
    else $error("match reported with an error status");

  a_match_closer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && a_matched |-> a_kept && (a_cmd == CMD_RSQ || a_cmd == CMD_RPAR))
    else $error("match reported on a non-closer");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !a_kept |-> m_tdata[38:1] == '0)
    else $error("dropped byte carries payload");

  a_no_unclosed_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> a_status != ST_UNCLOSED)
    else $error("unclosed verdict before the last word");
`endif

endmodule
`default_nettype wire
